/* hdl/lir_pkg.sv */
// shared types and constants of the linear interpolation resampler
// no dependencies; every other file of the block refers to it by scoped names
package lir_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int SAMPLE_W      = 16;
   localparam int STEP_W        = 21;
   localparam int RUN_CAP       = 64;
   localparam int CNT_W         = $clog2(RUN_CAP);
   localparam int CSR_IDX_W     = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEREO_SOURCE = 2'd0,
      CSR_BYPASS        = 2'd1,
      CSR_PHASE_STEP    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LEFT,
      S_RIGHT,
      S_CAP_L,
      S_CAP_R,
      S_EMIT,
      S_FINISH
   } state_type;

endpackage

/* hdl/lir_req_if.sv */
// request channel: one source frame per request
// depends on lir_pkg
interface lir_req_if;
   logic                  valid;
   logic                  ready;
   lir_pkg::sample_type   left_sample;
   lir_pkg::sample_type   right_sample;
   logic                  end_of_data;

   modport source (output valid, output left_sample, output right_sample,
                   output end_of_data, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input end_of_data, output ready);
endinterface

/* hdl/lir_rsp_if.sv */
// result channel: one stereo output frame with run and stream flags
// depends on lir_pkg
interface lir_rsp_if;
   logic                  valid;
   logic                  ready;
   lir_pkg::sample_type   left_out;
   lir_pkg::sample_type   right_out;
   logic                  sample_valid;
   logic                  run_last;
   logic                  stream_end;

   modport source (output valid, output left_out, output right_out,
                   output sample_valid, output run_last, output stream_end,
                   input ready);
   modport sink   (input valid, input left_out, input right_out,
                   input sample_valid, input run_last, input stream_end,
                   output ready);
endinterface

/* hdl/lir_lerp_unit.sv */
// shared two-stage interpolation unit: trunc(a + (b - a) * f), f in fixed point
// depends on lir_pkg; the product and a are registered first, then the result
module lir_lerp_unit #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  lir_pkg::sample_type   a,
   input  lir_pkg::sample_type   b,
   input  logic [FRAC_BITS-1:0]  f,
   output lir_pkg::sample_type   result
);

   localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
   localparam int NUM_W  = FRAC_BITS + lir_pkg::SAMPLE_W + 2;

   logic signed [DIFF_W-1:0]  diff;
   logic signed [NUM_W-1:0]   prod_in;
   logic signed [NUM_W-1:0]   prod_ff;
   lir_pkg::sample_type       base_ff;
   logic signed [NUM_W-1:0]   num;
   logic signed [NUM_W-1:0]   adj;
   logic signed [NUM_W-1:0]   quot;
   lir_pkg::sample_type       result_in;
   lir_pkg::sample_type       result_ff;

   assign diff    = DIFF_W'(b) - DIFF_W'(a);
   assign prod_in = NUM_W'(diff * $signed({1'b0, f}));

   always_comb begin
      num = {{2{base_ff[lir_pkg::SAMPLE_W-1]}}, base_ff, {FRAC_BITS{1'b0}}} + prod_ff;
      if (num[NUM_W-1]) begin
         adj = num + NUM_W'((64'd1 << FRAC_BITS) - 64'd1);
      end else begin
         adj = num;
      end
      quot      = adj >>> FRAC_BITS;
      result_in = quot[lir_pkg::SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      base_ff   <= a;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* hdl/linear_interp_resampler.sv */
// sequence: a bypass request goes from idle straight to emit, which loads the output register;
// an interpolated request runs idle and check steps, then per output left and right through
// the one shared multiplier, capture of left and right, and emit, then a finish step; a bare
// end marker runs idle, check, finish and emit
// throughput: one request at a time, at most 64 outputs per request; stalls hold emit
// reset: synchronous, clears control state, held frame and phase, registers to defaults
module linear_interp_resampler #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lir_pkg::STEP_W-1:0]        csr_wr_data,
   lir_req_if.sink                           req_bus,
   lir_rsp_if.source                         rsp_bus
);

   localparam int PW    = FRAC_BITS + 5;
   localparam int SW    = ((PW > lir_pkg::STEP_W) ? PW : lir_pkg::STEP_W) + 1;
   localparam logic [PW-1:0] PHASE_ONE = PW'(64'd1 << FRAC_BITS);
   localparam logic [PW-1:0] PHASE_MAX = {PW{1'b1}};
   localparam logic [lir_pkg::STEP_W-1:0] STEP_RESET =
      lir_pkg::STEP_W'(64'd1 << FRAC_BITS);
   localparam logic [lir_pkg::CNT_W-1:0] CNT_LAST = lir_pkg::CNT_W'(lir_pkg::RUN_CAP - 1);

   lir_pkg::state_type state_ff, state_in;

   logic                        stereo_ff, stereo_in;
   logic                        bypass_ff, bypass_in;
   logic [lir_pkg::STEP_W-1:0]  step_ff, step_in;

   lir_pkg::sample_type         prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic                        have_prev_ff, have_prev_in;
   logic [PW-1:0]               phase_ff, phase_in;

   lir_pkg::sample_type         cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                        last_ff, last_in;
   logic [lir_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        any_ff, any_in;
   logic                        more_ff, more_in;
   logic                        term_ff, term_in;

   lir_pkg::sample_type         pend_l_ff, pend_l_in, pend_r_ff, pend_r_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        pend_run_last_ff, pend_run_last_in;
   logic                        pend_end_ff, pend_end_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   lir_pkg::sample_type         rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic                        rsp_sv_ff, rsp_sv_in;
   logic                        rsp_rl_ff, rsp_rl_in;
   logic                        rsp_se_ff, rsp_se_in;

   logic                        req_fire;
   logic                        slot_free;
   logic                        emit_load;
   logic                        phase_low;
   logic [SW-1:0]               phase_sum;
   logic [PW-1:0]               phase_sat;
   logic                        sat_low;
   lir_pkg::sample_type         req_r_eff;
   lir_pkg::sample_type         unit_a, unit_b, unit_result;

   assign req_bus.ready = (state_ff == lir_pkg::S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign emit_load     = (state_ff == lir_pkg::S_EMIT) && slot_free;
   assign phase_low     = (phase_ff < PHASE_ONE);
   assign phase_sum     = SW'(phase_ff) + SW'(step_ff);
   assign phase_sat     = (phase_sum > SW'(PHASE_MAX)) ? PHASE_MAX : phase_sum[PW-1:0];
   assign sat_low       = (phase_sat < PHASE_ONE);
   assign req_r_eff     = stereo_ff ? req_bus.right_sample : req_bus.left_sample;

   // shared multiplier: left operands first, right operands in the cycle after
   always_comb begin
      if (state_ff == lir_pkg::S_RIGHT) begin
         unit_a = prev_r_ff;
         unit_b = cur_r_ff;
      end else begin
         unit_a = prev_l_ff;
         unit_b = cur_l_ff;
      end
   end

   lir_lerp_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock  (clock),
      .a      (unit_a),
      .b      (unit_b),
      .f      (phase_ff[FRAC_BITS-1:0]),
      .result (unit_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lir_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = bypass_ff ? lir_pkg::S_EMIT : lir_pkg::S_CHECK;
            end
         end
         lir_pkg::S_CHECK: begin
            state_in = (have_prev_ff && phase_low) ? lir_pkg::S_LEFT : lir_pkg::S_FINISH;
         end
         lir_pkg::S_LEFT:  state_in = lir_pkg::S_RIGHT;
         lir_pkg::S_RIGHT: state_in = lir_pkg::S_CAP_L;
         lir_pkg::S_CAP_L: state_in = lir_pkg::S_CAP_R;
         lir_pkg::S_CAP_R: state_in = lir_pkg::S_EMIT;
         lir_pkg::S_EMIT: begin
            if (slot_free) begin
               if (term_ff) begin
                  state_in = lir_pkg::S_IDLE;
               end else if (more_ff) begin
                  state_in = lir_pkg::S_LEFT;
               end else begin
                  state_in = lir_pkg::S_FINISH;
               end
            end
         end
         lir_pkg::S_FINISH: begin
            state_in = (last_ff && !any_ff) ? lir_pkg::S_EMIT : lir_pkg::S_IDLE;
         end
         default: state_in = lir_pkg::S_IDLE;
      endcase
   end

   // datapath and registers
   always_comb begin
      stereo_in        = stereo_ff;
      bypass_in        = bypass_ff;
      step_in          = step_ff;
      prev_l_in        = prev_l_ff;
      prev_r_in        = prev_r_ff;
      have_prev_in     = have_prev_ff;
      phase_in         = phase_ff;
      cur_l_in         = cur_l_ff;
      cur_r_in         = cur_r_ff;
      last_in          = last_ff;
      cnt_in           = cnt_ff;
      any_in           = any_ff;
      more_in          = more_ff;
      term_in          = term_ff;
      pend_l_in        = pend_l_ff;
      pend_r_in        = pend_r_ff;
      pend_valid_in    = pend_valid_ff;
      pend_run_last_in = pend_run_last_ff;
      pend_end_in      = pend_end_ff;

      if (csr_wr_en) begin
         case (lir_pkg::csr_index_type'(csr_index))
            lir_pkg::CSR_STEREO_SOURCE: stereo_in = csr_wr_data[0];
            lir_pkg::CSR_BYPASS:        bypass_in = csr_wr_data[0];
            lir_pkg::CSR_PHASE_STEP:    step_in   = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         lir_pkg::S_IDLE: begin
            if (req_fire) begin
               cur_l_in = req_bus.left_sample;
               cur_r_in = req_r_eff;
               last_in  = req_bus.end_of_data;
               cnt_in   = '0;
               any_in   = 1'b0;
               more_in  = 1'b0;
               term_in  = bypass_ff;
               if (bypass_ff) begin
                  pend_l_in        = req_bus.left_sample;
                  pend_r_in        = req_r_eff;
                  pend_valid_in    = 1'b1;
                  pend_run_last_in = 1'b1;
                  pend_end_in      = req_bus.end_of_data;
                  if (req_bus.end_of_data) begin
                     have_prev_in = 1'b0;
                     phase_in     = '0;
                  end
               end
            end
         end
         lir_pkg::S_CAP_L: begin
            pend_l_in = unit_result;
         end
         lir_pkg::S_CAP_R: begin
            pend_r_in        = unit_result;
            pend_valid_in    = 1'b1;
            phase_in         = phase_sat;
            more_in          = sat_low && (cnt_ff != CNT_LAST);
            pend_run_last_in = !(sat_low && (cnt_ff != CNT_LAST));
            pend_end_in      = !(sat_low && (cnt_ff != CNT_LAST)) && last_ff;
            cnt_in           = cnt_ff + lir_pkg::CNT_W'(1);
            any_in           = 1'b1;
         end
         lir_pkg::S_FINISH: begin
            if (have_prev_ff) begin
               phase_in = phase_low ? '0 : (phase_ff - PHASE_ONE);
            end
            prev_l_in    = cur_l_ff;
            prev_r_in    = cur_r_ff;
            have_prev_in = 1'b1;
            if (last_ff) begin
               have_prev_in = 1'b0;
               phase_in     = '0;
               if (!any_ff) begin
                  pend_l_in        = '0;
                  pend_r_in        = '0;
                  pend_valid_in    = 1'b0;
                  pend_run_last_in = 1'b1;
                  pend_end_in      = 1'b1;
                  term_in          = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_rl_in    = rsp_rl_ff;
      rsp_se_in    = rsp_se_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_l_in     = pend_l_ff;
         rsp_r_in     = pend_r_ff;
         rsp_sv_in    = pend_valid_ff;
         rsp_rl_in    = pend_run_last_ff;
         rsp_se_in    = pend_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lir_pkg::S_IDLE;
         stereo_ff    <= 1'b1;
         bypass_ff    <= 1'b1;
         step_ff      <= STEP_RESET;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         any_ff       <= 1'b0;
         more_ff      <= 1'b0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stereo_ff    <= stereo_in;
         bypass_ff    <= bypass_in;
         step_ff      <= step_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         any_ff       <= any_in;
         more_ff      <= more_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_l_ff         <= cur_l_in;
      cur_r_ff         <= cur_r_in;
      pend_l_ff        <= pend_l_in;
      pend_r_ff        <= pend_r_in;
      pend_valid_ff    <= pend_valid_in;
      pend_run_last_ff <= pend_run_last_in;
      pend_end_ff      <= pend_end_in;
      rsp_l_ff         <= rsp_l_in;
      rsp_r_ff         <= rsp_r_in;
      rsp_sv_ff        <= rsp_sv_in;
      rsp_rl_ff        <= rsp_rl_in;
      rsp_se_ff        <= rsp_se_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.left_out     = rsp_l_ff;
   assign rsp_bus.right_out    = rsp_r_ff;
   assign rsp_bus.sample_valid = rsp_sv_ff;
   assign rsp_bus.run_last     = rsp_rl_ff;
   assign rsp_bus.stream_end   = rsp_se_ff;

   // pending output waits while the result slot is full
   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lir_pkg::S_EMIT) && rsp_valid_ff && !rsp_bus.ready
      |=> (state_ff == lir_pkg::S_EMIT))
      else $error("emit left before the result slot was free");

   // run stops at the cap
   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lir_pkg::S_CAP_R) && (cnt_ff == CNT_LAST)
      |=> !more_ff && pend_run_last_ff)
      else $error("run continued past the cap");

   // bypass request goes straight to a single emit
   a_bypass_path: assert property (@(posedge clock) disable iff (reset)
      req_fire && bypass_ff |=> (state_ff == lir_pkg::S_EMIT) && term_ff && pend_valid_ff)
      else $error("bypass request did not produce one result");

   // end of stream clears held frame and phase
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lir_pkg::S_FINISH) && last_ff |=> !have_prev_ff && (phase_ff == '0))
      else $error("end of data left state behind");

endmodule
